### rtl/sorted_table_binary_search_defines.svh
// Assertion macros shared by the sorted table search modules.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define STBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted table search: assertion failed");

// Checks that cons holds in the cycle after ante.
`define STBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted table search: assertion failed");

`endif

### rtl/stbs_pkg.sv
// Shared constants, payload types and control structs of the sorted table search.
package stbs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_W       = 8;
  localparam int SLOT_W      = 5;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = 2;
  localparam int DATA_W      = 32;

  localparam logic [ADDR_W-1:0] REG_ENTRIES = ADDR_W'(0);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } stbs_in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
  } stbs_out_t;

  typedef struct packed {
    logic start;
    logic load;
    logic probe;
    logic update;
    logic push;
  } stbs_cmd_t;

  typedef struct packed {
    logic window_empty;
    logic hit;
    logic out_free;
  } stbs_sts_t;

endpackage

### rtl/stbs_cfg.sv
// APB-style register block holding the entries-in-use count.
module stbs_cfg
  import stbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  entries_r
);

  logic [CNT_W-1:0] entries_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_ENTRIES);

  always_comb begin
    entries_nxt = entries_r;
    if (wr_en) begin
      entries_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else begin
      entries_r <= entries_nxt;
    end
  end

  assign prdata = (paddr == REG_ENTRIES) ? {{(DATA_W-CNT_W){1'b0}}, entries_r} : '0;

endmodule

### rtl/stbs_dp.sv
// Search datapath: key table, search window, probe compare and result register.
`include "sorted_table_binary_search_defines.svh"

module stbs_dp
  import stbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  stbs_in_t         in_data,
  input  logic [CNT_W-1:0] entries,
  input  stbs_cmd_t        cmd,
  output stbs_sts_t        sts,
  output logic             out_valid,
  input  logic             out_stall,
  output stbs_out_t        out_data
);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rdata_r;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_r;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] count;
  logic             res_found_r;
  logic [CNT_W-1:0] res_pos_r;
  logic             out_valid_r;
  stbs_out_t        out_data_r;
  logic             less;

  // A count above the table depth searches the whole table.
  assign count = (entries > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries;

  // The window is [lo, hi) with hi one past the last candidate.
  assign span = hi_r - lo_r - CNT_W'(1);
  assign mid  = lo_r + (span >> 1);
  assign less = rdata_r < key_r;

  assign sts.window_empty = lo_r >= hi_r;
  assign sts.hit          = rdata_r == key_r;
  assign sts.out_free     = !out_valid_r || !out_stall;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.start) begin
      lo_nxt = '0;
      hi_nxt = count;
    end else if (cmd.update && !sts.hit) begin
      if (less) begin
        lo_nxt = mid_r + CNT_W'(1);
      end else begin
        hi_nxt = mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_data.slot] <= in_data.key;
    end
    if (cmd.probe) begin
      rdata_r <= mem[mid[IDX_W-1:0]];
      mid_r   <= mid;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.start) begin
      key_r       <= in_data.key;
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end else if (cmd.update && sts.hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= mid_r + CNT_W'(1);
    end
    if (cmd.push) begin
      out_data_r.found    <= res_found_r;
      out_data_r.position <= res_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STBS_ASSERT_SAME(a_probe_in_window, cmd.update, (mid_r >= lo_r) && (mid_r < hi_r))
  `STBS_ASSERT_NEXT(a_push_sets_valid, cmd.push, out_valid_r)
  `STBS_ASSERT_NEXT(a_stalled_result_held, out_valid_r && out_stall && !cmd.push, out_valid_r)

endmodule

### rtl/stbs_ctrl.sv
// Search controller: sequences loads, probe rounds and result hand-off.
`include "sorted_table_binary_search_defines.svh"

module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_kind,
  input  stbs_sts_t sts,
  output stbs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CHECK   = 4'b0010,
    S_COMPARE = 4'b0100,
    S_DONE    = 4'b1000
  } stbs_state_t;

  stbs_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_SEARCH) begin
            cmd.start = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.window_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.hit ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        // The result waits here while the output register is full and stalled.
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `STBS_ASSERT_NEXT(a_push_returns_idle, cmd.push, state_r == S_IDLE)
  `STBS_ASSERT_NEXT(a_done_waits, (state_r == S_DONE) && !sts.out_free, state_r == S_DONE)

endmodule

### rtl/sorted_table_binary_search.sv
// A load request writes one key into the table and gives no result, and the
// block stays ready for the next request. A search request runs a binary search
// over the first entries_in_use slots with one table probe per round (a
// registered read of the single-port key table at the window midpoint, then
// the compare). A search ends on a hit or when the window is empty; its
// result then waits in the done state until the output register is free, and
// the next request is taken once it has been pushed. For a full 32-entry
// table a search makes at most 6 probes. Results sit in an output register,
// so the next request is taken while a result still waits downstream. The
// table has no reset: search only slots that were loaded.
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stbs_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stbs_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] entries;
  stbs_cmd_t        cmd;
  stbs_sts_t        sts;

  stbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .entries_r (entries)
  );

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_data.kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .entries   (entries),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
